// ===== sv/cdq_pkg.sv =====
// operation and status codes of the circular double-ended queue
package cdq_pkg;

   localparam int WORD_W = 32;
   localparam int OP_W   = 3;
   localparam int ST_W   = 2;
   localparam int CAP_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef logic signed [WORD_W-1:0] word_type;

endpackage

// ===== sv/circular_double_ended_queue_unit.sv =====
// circular double-ended queue: synchronous slot memory, pointers and response register
//
// Double-ended queue of signed 32-bit words in a circular slot memory of DEPTH
// entries, of which the first csr_wdata entries (clamped to 1..DEPTH) are in use.
// A request word carries one of six operations (push, pop or peek at either end)
// and always gives one response word with the data read, a status code and the
// full and empty flags as they stand after the operation. One request is taken
// per clock while the response register is free or being emptied in the same
// cycle; a request stalls only while a previous response waits. Pushes write the
// slot memory at the accept edge; pops and peeks read it at the accept edge and
// the memory's registered read data is the response data, so every operation
// responds in the cycle after acceptance. A capacity write empties the queue;
// slot contents are kept but are never read before being written again.
module circular_double_ended_queue_unit
   import cdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_op,
   input  logic signed [WORD_W-1:0] req_data_in,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WORD_W-1:0] rsp_data_out,
   output logic [ST_W-1:0]         rsp_status,
   output logic                    rsp_is_full,
   output logic                    rsp_is_empty,

   input  logic                    csr_wen,
   input  logic [CAP_W-1:0]        csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // slot memory, one write and one registered read port
   word_type       slot_ff [DEPTH];
   word_type       mem_rd_ff;

   logic [CAP_W-1:0] capacity_ff;
   logic [AW-1:0]  head_ff, head_in;
   logic [AW-1:0]  tail_ff, tail_in;
   logic           empty_ff, empty_in;

   logic           rsp_valid_ff;
   word_type       rsp_data_ff, rsp_data_in;
   logic           rsp_from_mem_ff, rsp_from_mem_in;
   logic [ST_W-1:0] rsp_status_ff, rsp_status_in;
   logic           rsp_full_ff, rsp_full_in;
   logic           rsp_empty_ff;

   logic           accept;
   logic [AW-1:0]  last;
   logic           is_push, is_read, is_pop, at_front, full_now;
   logic           mem_wen, mem_ren;
   logic [AW-1:0]  mem_waddr, mem_raddr;

   function automatic logic queue_full(input logic [AW-1:0] h, input logic [AW-1:0] t,
                                       input logic e, input logic [AW-1:0] lst);
      logic wrap_full;
      logic next_full;
      begin
         wrap_full = (h == '0) && (t == lst);
         // plain increment, no wrap
         next_full = ({1'b0, h} == ({1'b0, t} + {{AW{1'b0}}, 1'b1}));
         queue_full = !e && (wrap_full || next_full);
      end
   endfunction

   // last usable index, capacity clamped to 1..DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         last = '0;
      end else if (int'(capacity_ff) > DEPTH) begin
         last = AW'(DEPTH - 1);
      end else begin
         last = AW'(capacity_ff - 5'd1);
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   assign is_push  = (req_op == OP_PUSH_FRONT) || (req_op == OP_PUSH_REAR);
   assign is_pop   = (req_op == OP_POP_FRONT) || (req_op == OP_POP_REAR);
   assign is_read  = is_pop || (req_op == OP_PEEK_FRONT) || (req_op == OP_PEEK_REAR);
   assign at_front = (req_op == OP_POP_FRONT) || (req_op == OP_PEEK_FRONT);
   assign full_now = queue_full(head_ff, tail_ff, empty_ff, last);

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      empty_in        = empty_ff;
      rsp_status_in   = ST_OK;
      rsp_data_in     = '0;
      rsp_from_mem_in = 1'b0;
      mem_wen         = 1'b0;
      mem_waddr       = '0;
      mem_ren         = 1'b0;
      mem_raddr       = at_front ? head_ff : tail_ff;

      if (is_push) begin
         if (full_now) begin
            rsp_status_in = ST_OVERFLOW;
         end else if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            mem_wen  = 1'b1;
         end else if (req_op == OP_PUSH_FRONT) begin
            head_in   = (head_ff == '0) ? last : head_ff - 1'b1;
            mem_wen   = 1'b1;
            mem_waddr = head_in;
         end else begin
            tail_in   = (tail_ff >= last) ? '0 : tail_ff + 1'b1;
            mem_wen   = 1'b1;
            mem_waddr = tail_in;
         end
      end else if (is_read) begin
         if (empty_ff) begin
            rsp_status_in = ST_EMPTY;
            rsp_data_in   = '1;
         end else begin
            mem_ren         = 1'b1;
            rsp_from_mem_in = 1'b1;
            if (is_pop) begin
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (req_op == OP_POP_FRONT) begin
                  head_in = (head_ff >= last) ? '0 : head_ff + 1'b1;
               end else begin
                  tail_in = (tail_ff == '0) ? last : tail_ff - 1'b1;
               end
            end
         end
      end

      rsp_full_in = queue_full(head_in, tail_in, empty_in, last);
   end

   always_ff @(posedge clock) begin
      if (accept && mem_wen) begin
         slot_ff[mem_waddr] <= req_data_in;
      end
      if (accept && mem_ren) begin
         mem_rd_ff <= slot_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            capacity_ff <= csr_wdata;
            head_ff     <= '0;
            tail_ff     <= '0;
            empty_ff    <= 1'b1;
         end else if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff     <= rsp_data_in;
         rsp_from_mem_ff <= rsp_from_mem_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_full_ff     <= rsp_full_in;
         rsp_empty_ff    <= empty_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_from_mem_ff ? mem_rd_ff : rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_is_full  = rsp_full_ff;
   assign rsp_is_empty = rsp_empty_ff;

   // every accepted word gives a response on the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word gave no response");

   // an empty queue always has both pointers parked at zero
   a_empty_parks_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty queue with pointers away from zero");

   // pointers never leave the range in use
   a_ptrs_in_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= last) && (tail_ff <= last))
      else $error("pointer beyond capacity");

   // an empty status reports -1 and an empty queue
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_EMPTY)) |->
         (rsp_empty_ff && (rsp_data_out == '1)))
      else $error("empty status without empty flag or -1 data");

   // an overflow only happens on a full queue that stays full
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_OVERFLOW)) |-> (rsp_full_ff && !rsp_empty_ff))
      else $error("overflow reported on a queue that is not full");

endmodule
